// File: rtl/core/bdar_pkg.sv
// shared definitions for the button debounce and auto-repeat core
// event codes, register indexes and port widths; no dependencies
package bdar_pkg;

   localparam int unsigned TIME_W   = 32;  // millisecond timestamp width
   localparam int unsigned CFG_W    = 16;  // configuration register width
   localparam int unsigned CNT_W    = 16;  // repeat count width
   localparam int unsigned REQ_DW   = 40;  // req tdata, padded to whole bytes
   localparam int unsigned RSP_DW   = 8;   // rsp tdata, padded to whole bytes
   localparam int unsigned CSR_IW   = 2;   // csr index width

   typedef enum logic [1:0] {
      EV_NONE     = 2'd0,
      EV_PRESSED  = 2'd1,
      EV_REPEAT   = 2'd2,
      EV_RELEASED = 2'd3
   } event_type;

   typedef enum logic [CSR_IW-1:0] {
      CSR_BLANK_TIME    = 2'd0,
      CSR_HOLD_DELAY    = 2'd1,
      CSR_REPEAT_PERIOD = 2'd2
   } csr_index_type;

   localparam logic [CFG_W-1:0] BLANK_TIME_RST    = 16'd10;
   localparam logic [CFG_W-1:0] HOLD_DELAY_RST    = 16'd400;
   localparam logic [CFG_W-1:0] REPEAT_PERIOD_RST = 16'd50;

endpackage

// File: rtl/core/button_debounce_autorepeat_core.sv
// button debounce with auto-repeat, top level
// uses bdar_pkg for event codes, register indexes and widths
//
// Each req transaction carries one button sample (raw level and a free-running
// millisecond timestamp) and yields exactly one rsp transaction with an event:
// none, pressed, held repeat or released. A level change is taken only once the
// blanking window of the previous accepted change has ended; a held press
// reports one repeat event per sample while (elapsed hold time) / repeat_period
// is above the repeat count, the count saturating at 65535. A sample keeps the
// core busy through a bit-serial subtractor chain that walks the 32 timestamp
// bits one per cycle while a 16-step shift-add multiplier forms (count + 1) *
// repeat_period for the repeat test, then through a decision state that loads
// the event into the output register. A new sample is taken only back in idle,
// not before the last one is through. The result sits in an output register,
// so a new sample is taken while it waits; a stalled rsp side holds the
// decision state. Registers must be written only while no sample is in flight;
// the block itself does not enforce this.
module button_debounce_autorepeat_core
   import bdar_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // sample channel
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [REQ_DW-1:0] req_tdata,   // [0] level, [32:1] now_ms, rest zero
   // event channel
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_DW-1:0] rsp_tdata,   // [1:0] event_res, rest zero
   // register write port
   input  logic              csr_we,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [CFG_W-1:0]  csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_DECIDE
   } state_type;

   // control
   state_type          state_ff, state_in;
   logic [4:0]         bit_cnt_ff, bit_cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   event_type          rsp_event_ff, rsp_event_in;

   // configuration
   logic [CFG_W-1:0]   blank_ff, blank_in;
   logic [CFG_W-1:0]   hold_ff, hold_in;
   logic [CFG_W-1:0]   period_ff, period_in;

   // debounce state
   logic               acc_level_ff, acc_level_in;
   logic [TIME_W-1:0]  win_end_ff, win_end_in;     // rotates once per sample
   logic [CNT_W-1:0]   count_ff, count_in;

   // per-sample working registers
   logic               level_ff, level_in;
   logic [TIME_W-1:0]  now_sr_ff, now_sr_in;
   logic [CFG_W-1:0]   blank_sr_ff, blank_sr_in;
   logic [CFG_W-1:0]   hold_sr_ff, hold_sr_in;
   logic [TIME_W-1:0]  diff_sr_ff, diff_sr_in;     // now - win_end + blank - hold
   logic [TIME_W-1:0]  new_we_sr_ff, new_we_sr_in; // now + blank
   logic               b1_ff, b1_in;               // borrow of now - win_end
   logic               c2_ff, c2_in;               // carry of + blank
   logic               b3_ff, b3_in;               // borrow of - hold
   logic               c4_ff, c4_in;               // carry of now + blank
   logic               nz1_ff, nz1_in;             // now - win_end nonzero
   logic               nz3_ff, nz3_in;             // hold difference nonzero
   logic               sign1_ff, sign1_in;         // msb of now - win_end
   logic [CNT_W:0]     mcand_ff, mcand_in;         // count + 1
   logic [33:0]        prod_ff, prod_in;           // shift-add product register

   // serial datapath bits
   logic               a_bit, w_bit, bl_bit, ho_bit;
   logic               d1, s2, d3, nw;
   logic [17:0]        prod_sum;
   logic [CFG_W-1:0]   period_eff;
   logic               window_over, hold_over, repeat_due;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DW-2){1'b0}}, rsp_event_ff};

   assign period_eff = (period_ff == '0) ? {{(CFG_W-1){1'b0}}, 1'b1} : period_ff;

   // one bit of each time difference per cycle, lsb first
   assign a_bit  = now_sr_ff[0];
   assign w_bit  = win_end_ff[0];
   assign bl_bit = blank_sr_ff[0];
   assign ho_bit = hold_sr_ff[0];
   assign d1     = a_bit ^ w_bit ^ b1_ff;
   assign s2     = d1 ^ bl_bit ^ c2_ff;
   assign d3     = s2 ^ ho_bit ^ b3_ff;
   assign nw     = a_bit ^ bl_bit ^ c4_ff;

   // multiplier step: add the multiplicand into the upper half when the lsb is set
   assign prod_sum = prod_ff[33:16] + (prod_ff[0] ? {1'b0, mcand_ff} : 18'd0);

   // decision terms, valid in the decide state
   assign window_over = nz1_ff && !sign1_ff;
   assign hold_over   = nz3_ff && !diff_sr_ff[TIME_W-1];
   assign repeat_due  = hold_over && (count_ff != {CNT_W{1'b1}}) &&
                        ({1'b0, diff_sr_ff} >= prod_ff[32:0]);

   always_comb begin
      state_in      = state_ff;
      bit_cnt_in    = bit_cnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_event_in  = rsp_event_ff;
      blank_in      = blank_ff;
      hold_in       = hold_ff;
      period_in     = period_ff;
      acc_level_in  = acc_level_ff;
      win_end_in    = win_end_ff;
      count_in      = count_ff;
      level_in      = level_ff;
      now_sr_in     = now_sr_ff;
      blank_sr_in   = blank_sr_ff;
      hold_sr_in    = hold_sr_ff;
      diff_sr_in    = diff_sr_ff;
      new_we_sr_in  = new_we_sr_ff;
      b1_in         = b1_ff;
      c2_in         = c2_ff;
      b3_in         = b3_ff;
      c4_in         = c4_ff;
      nz1_in        = nz1_ff;
      nz3_in        = nz3_ff;
      sign1_in      = sign1_ff;
      mcand_in      = mcand_ff;
      prod_in       = prod_ff;

      // register writes must arrive only while idle; the core does not enforce it
      if (csr_we) begin
         case (csr_index)
            CSR_BLANK_TIME:    blank_in  = csr_wdata;
            CSR_HOLD_DELAY:    hold_in   = csr_wdata;
            CSR_REPEAT_PERIOD: period_in = csr_wdata;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               level_in    = req_tdata[0];
               now_sr_in   = req_tdata[TIME_W:1];
               blank_sr_in = blank_ff;
               hold_sr_in  = hold_ff;
               b1_in       = 1'b0;
               c2_in       = 1'b0;
               b3_in       = 1'b0;
               c4_in       = 1'b0;
               nz1_in      = 1'b0;
               nz3_in      = 1'b0;
               bit_cnt_in  = '0;
               mcand_in    = {1'b0, count_ff} + {{CNT_W{1'b0}}, 1'b1};
               prod_in     = {18'd0, period_eff};
               state_in    = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            now_sr_in    = {1'b0, now_sr_ff[TIME_W-1:1]};
            win_end_in   = {w_bit, win_end_ff[TIME_W-1:1]};
            blank_sr_in  = {1'b0, blank_sr_ff[CFG_W-1:1]};
            hold_sr_in   = {1'b0, hold_sr_ff[CFG_W-1:1]};
            diff_sr_in   = {d3, diff_sr_ff[TIME_W-1:1]};
            new_we_sr_in = {nw, new_we_sr_ff[TIME_W-1:1]};
            b1_in        = (~a_bit & w_bit) | (~(a_bit ^ w_bit) & b1_ff);
            c2_in        = (d1 & bl_bit) | (d1 & c2_ff) | (bl_bit & c2_ff);
            b3_in        = (~s2 & ho_bit) | (~(s2 ^ ho_bit) & b3_ff);
            c4_in        = (a_bit & bl_bit) | (a_bit & c4_ff) | (bl_bit & c4_ff);
            nz1_in       = nz1_ff | d1;
            nz3_in       = nz3_ff | d3;
            sign1_in     = d1;
            if (!bit_cnt_ff[4]) begin
               prod_in = {1'b0, prod_sum, prod_ff[15:1]};
            end
            bit_cnt_in = bit_cnt_ff + 5'd1;
            if (bit_cnt_ff == 5'd31) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_event_in = EV_NONE;
               if ((level_ff != acc_level_ff) && window_over) begin
                  win_end_in   = new_we_sr_ff;
                  acc_level_in = level_ff;
                  if (level_ff) begin
                     count_in     = '0;
                     rsp_event_in = EV_PRESSED;
                  end else begin
                     rsp_event_in = EV_RELEASED;
                  end
               end else if (level_ff && repeat_due) begin
                  count_in     = count_ff + {{(CNT_W-1){1'b0}}, 1'b1};
                  rsp_event_in = EV_REPEAT;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bit_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_event_ff <= EV_NONE;
         blank_ff     <= BLANK_TIME_RST;
         hold_ff      <= HOLD_DELAY_RST;
         period_ff    <= REPEAT_PERIOD_RST;
         acc_level_ff <= 1'b0;
         win_end_ff   <= '0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         bit_cnt_ff   <= bit_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_event_ff <= rsp_event_in;
         blank_ff     <= blank_in;
         hold_ff      <= hold_in;
         period_ff    <= period_in;
         acc_level_ff <= acc_level_in;
         win_end_ff   <= win_end_in;
         count_ff     <= count_in;
      end
      // working registers, no reset needed
      level_ff     <= level_in;
      now_sr_ff    <= now_sr_in;
      blank_sr_ff  <= blank_sr_in;
      hold_sr_ff   <= hold_sr_in;
      diff_sr_ff   <= diff_sr_in;
      new_we_sr_ff <= new_we_sr_in;
      b1_ff        <= b1_in;
      c2_ff        <= c2_in;
      b3_ff        <= b3_in;
      c4_ff        <= c4_in;
      nz1_ff       <= nz1_in;
      nz3_ff       <= nz3_in;
      sign1_ff     <= sign1_in;
      mcand_ff     <= mcand_in;
      prod_ff      <= prod_in;
   end

endmodule

// File: rtl/core/bdar_checker.sv
// port-level checks for button_debounce_autorepeat_core
// uses bdar_pkg widths; bound to the top level below
module bdar_checker
   import bdar_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic [REQ_DW-1:0] req_tdata,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [RSP_DW-1:0] rsp_tdata,
   input logic              csr_we,
   input logic [CSR_IW-1:0] csr_index,
   input logic [CFG_W-1:0]  csr_wdata
);

   // no event pending right after reset
   a_rst_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // a sample keeps the block busy for the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("sample taken in back-to-back cycles");

   // an event is on rsp once a sample has passed the shift and decide states, its own or an older stalled one
   a_result_arrives: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> ##34 rsp_tvalid)
      else $error("no event after a sample");

   // stalled event holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled event changed");

   // padding bits of the event stay zero
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RSP_DW-1:2] == '0))
      else $error("rsp_tdata padding not zero");

endmodule

bind button_debounce_autorepeat_core bdar_checker u_bdar_checker (.*);
